@@ hw/rtl/isadma_pkg.sv @@
// ----------------------------------------------------------------------------
// ISA DMA controller package
// Shared widths, port numbers, result codes and control structs of the
// emulated four-channel ISA DMA controller.
// ----------------------------------------------------------------------------
package isadma_pkg;

    // Page size that a transfer piece never crosses (a power of two).
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = PAGE_BITS + 1;

    localparam int NUM_CHANS  = 4;
    localparam int CHAN_W     = 2;
    localparam int ADDR_W     = 24;
    localparam int LEN_W      = 16;
    localparam int COUNT_W    = 17;
    localparam int PIECE_W    = 13;
    localparam int MASK_W     = 6;
    localparam int MODE_W     = 2;
    localparam int PORT_W     = 16;
    localparam int DATA_W     = 8;
    localparam int STATUS_W   = 2;

    // At most this many results come out of one transfer request.
    localparam int MAX_PIECES = 17;
    localparam int IDX_W      = $clog2(MAX_PIECES);

    // Only channel 2 has its page, address and count ports decoded.
    localparam logic [CHAN_W-1:0] PAGED_CHAN = 2'd2;

    // Command codes.
    localparam logic CMD_PORT_WRITE = 1'b0;
    localparam logic CMD_TRANSFER   = 1'b1;

    // Result kinds.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_PIECE  = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PORT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_MODE = 2'd2;

    // Decoded I/O ports.
    localparam logic [PORT_W-1:0] PORT_ADDR2  = 16'h0004;
    localparam logic [PORT_W-1:0] PORT_COUNT2 = 16'h0005;
    localparam logic [PORT_W-1:0] PORT_MASK   = 16'h000a;
    localparam logic [PORT_W-1:0] PORT_MODE   = 16'h000b;
    localparam logic [PORT_W-1:0] PORT_CLEAR  = 16'h000c;
    localparam logic [PORT_W-1:0] PORT_PAGE2  = 16'h0081;

    // Register file write request from the sequencer.
    typedef struct packed {
        logic                port_we;
        logic [PORT_W-1:0]   port;
        logic [DATA_W-1:0]   data;
        logic                addr_we;
        logic [CHAN_W-1:0]   ch;
        logic [ADDR_W-1:0]   addr;
    } t_reg_wr;

    // Result of one step of the piece unit.
    typedef struct packed {
        logic [COUNT_W-1:0]  piece;
        logic [ADDR_W-1:0]   next_addr;
        logic                final_piece;
    } t_piece_res;

endpackage

@@ hw/rtl/isadma_in_if.sv @@
// ----------------------------------------------------------------------------
// ISA DMA request channel
// Valid/ready channel that carries port writes and transfer requests.
// ----------------------------------------------------------------------------
interface isadma_in_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic [isadma_pkg::PORT_W-1:0]     port;
    logic [isadma_pkg::DATA_W-1:0]     data_byte;
    logic [isadma_pkg::CHAN_W-1:0]     channel;
    logic [isadma_pkg::COUNT_W-1:0]    byte_count;
    logic                              direction;

    modport source (output valid, command, port, data_byte, channel, byte_count,
                    direction, input ready);
    modport sink (input valid, command, port, data_byte, channel, byte_count,
                  direction, output ready);
endinterface

@@ hw/rtl/isadma_out_if.sv @@
// ----------------------------------------------------------------------------
// ISA DMA result channel
// Valid/ready channel that carries port-write status and transfer pieces.
// ----------------------------------------------------------------------------
interface isadma_out_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [isadma_pkg::STATUS_W-1:0]   status;
    logic [isadma_pkg::ADDR_W-1:0]     mem_address;
    logic [isadma_pkg::PIECE_W-1:0]    piece_length;
    logic [isadma_pkg::COUNT_W-1:0]    buffer_offset;
    logic                              to_buffer;
    logic [isadma_pkg::COUNT_W-1:0]    granted_count;
    logic                              last;

    modport source (output valid, kind, status, mem_address, piece_length,
                    buffer_offset, to_buffer, granted_count, last, input ready);
    modport sink (input valid, kind, status, mem_address, piece_length,
                  buffer_offset, to_buffer, granted_count, last, output ready);
endinterface

@@ hw/rtl/isadma_regs.sv @@
// ----------------------------------------------------------------------------
// ISA DMA register file
// Channel address, length, mask and mode registers, the byte flip-flop and
// the port decode that updates them and reports a status.
// ----------------------------------------------------------------------------
module isadma_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  isadma_pkg::t_reg_wr                 i_wr,
    input  logic [isadma_pkg::CHAN_W-1:0]       i_rd_ch,
    output logic [isadma_pkg::ADDR_W-1:0]       o_rd_addr,
    output logic [isadma_pkg::LEN_W-1:0]        o_rd_len,
    output logic [isadma_pkg::STATUS_W-1:0]     o_status
);

    logic [isadma_pkg::ADDR_W-1:0] r_chan_address [isadma_pkg::NUM_CHANS];
    logic [isadma_pkg::LEN_W-1:0]  r_chan_length  [isadma_pkg::NUM_CHANS];
    logic [isadma_pkg::MASK_W-1:0] r_chan_mask    [isadma_pkg::NUM_CHANS];
    logic [isadma_pkg::MODE_W-1:0] r_chan_mode    [isadma_pkg::NUM_CHANS];
    logic                          r_byte_ff;
    logic [isadma_pkg::CHAN_W-1:0] wr_sel;

    assign wr_sel    = i_wr.data[isadma_pkg::CHAN_W-1:0];
    assign o_rd_addr = r_chan_address[i_rd_ch];
    assign o_rd_len  = r_chan_length[i_rd_ch];

    // Status of the port write that is presented on i_wr.
    always_comb begin
        if (i_wr.port == isadma_pkg::PORT_MODE) begin
            o_status = (i_wr.data[7:4] == 4'd0) ? isadma_pkg::ST_BAD_MODE
                                                : isadma_pkg::ST_OK;
        end else if (i_wr.port inside {isadma_pkg::PORT_MASK, isadma_pkg::PORT_CLEAR,
                                       isadma_pkg::PORT_PAGE2, isadma_pkg::PORT_ADDR2,
                                       isadma_pkg::PORT_COUNT2}) begin
            o_status = isadma_pkg::ST_OK;
        end else begin
            o_status = isadma_pkg::ST_NO_PORT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < isadma_pkg::NUM_CHANS; i++) begin
                r_chan_address[i] <= '0;
                r_chan_length[i]  <= '0;
                r_chan_mask[i]    <= '0;
                r_chan_mode[i]    <= '0;
            end
            r_byte_ff <= 1'b0;
        end else begin
            if (i_wr.port_we) begin
                case (i_wr.port)
                    isadma_pkg::PORT_MASK: begin
                        r_chan_mask[wr_sel] <= i_wr.data[7:2];
                    end
                    isadma_pkg::PORT_MODE: begin
                        r_chan_mode[wr_sel] <= i_wr.data[3:2];
                    end
                    isadma_pkg::PORT_CLEAR: begin
                        r_byte_ff <= 1'b0;
                    end
                    isadma_pkg::PORT_PAGE2: begin
                        r_chan_address[isadma_pkg::PAGED_CHAN][23:16] <= i_wr.data;
                    end
                    isadma_pkg::PORT_ADDR2: begin
                        if (r_byte_ff) begin
                            r_chan_address[isadma_pkg::PAGED_CHAN][15:8] <= i_wr.data;
                        end else begin
                            r_chan_address[isadma_pkg::PAGED_CHAN][7:0] <= i_wr.data;
                        end
                        r_byte_ff <= ~r_byte_ff;
                    end
                    isadma_pkg::PORT_COUNT2: begin
                        if (r_byte_ff) begin
                            r_chan_length[isadma_pkg::PAGED_CHAN][15:8] <= i_wr.data;
                        end else begin
                            r_chan_length[isadma_pkg::PAGED_CHAN][7:0] <= i_wr.data;
                        end
                        r_byte_ff <= ~r_byte_ff;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_wr.addr_we) begin
                r_chan_address[i_wr.ch] <= i_wr.addr;
            end
        end
    end

endmodule

@@ hw/rtl/isadma_piece_unit.sv @@
// ----------------------------------------------------------------------------
// ISA DMA piece unit
// Shared step of the transfer split: bytes left in the current page, the
// piece length, the advanced channel address and the final-piece flag.
// ----------------------------------------------------------------------------
module isadma_piece_unit (
    input  logic [isadma_pkg::ADDR_W-1:0]   i_addr,
    input  logic [isadma_pkg::COUNT_W-1:0]  i_rem,
    input  logic [isadma_pkg::IDX_W-1:0]    i_idx,
    output isadma_pkg::t_piece_res          o_res
);

    logic [isadma_pkg::PAGE_W-1:0]  page_left;
    logic [isadma_pkg::COUNT_W-1:0] page_left_x;
    logic [isadma_pkg::COUNT_W-1:0] piece;
    logic [isadma_pkg::COUNT_W-1:0] step;
    logic                           at_limit;

    assign page_left   = isadma_pkg::PAGE_W'(isadma_pkg::PAGE_BYTES)
                       - {1'b0, i_addr[isadma_pkg::PAGE_BITS-1:0]};
    assign page_left_x = isadma_pkg::COUNT_W'(page_left);
    assign piece       = (page_left_x > i_rem) ? i_rem : page_left_x;
    assign at_limit    = (i_idx == isadma_pkg::IDX_W'(isadma_pkg::MAX_PIECES - 1));

    // On the last reportable piece the address skips over the whole remainder,
    // so pieces that are not reported still move the channel address.
    assign step = at_limit ? i_rem : piece;

    assign o_res.piece       = piece;
    assign o_res.next_addr   = i_addr + isadma_pkg::ADDR_W'(step);
    assign o_res.final_piece = (piece == i_rem) || at_limit;

endmodule

@@ hw/rtl/isa_dma_channel_controller.sv @@
// ----------------------------------------------------------------------------
// ISA DMA channel controller
// Emulated four-channel ISA DMA controller: port writes and page-split
// transfer requests, with results issued by a sequencer.
// ----------------------------------------------------------------------------
// A port write's status is registered in the EXEC state, once the output register is free.
// A transfer settles its grant in the EXEC state, then registers one piece per cycle
// in the PIECE state while the output register is free or being drained.
// A transfer gives up to 17 pieces, all from the single piece unit; a new request
// is taken only once the previous one is finished.
// Reset (i_rst_n low, synchronous) clears all channel registers and the flow.
// ----------------------------------------------------------------------------
module isa_dma_channel_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    isadma_in_if.sink     i_req,
    isadma_out_if.source  o_res
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_PIECE = 2'd2;

    logic [1:0] r_state, n_state;

    // Request held for the duration of its work.
    logic                                r_cmd;
    logic [isadma_pkg::PORT_W-1:0]       r_port;
    logic [isadma_pkg::DATA_W-1:0]       r_data;
    logic [isadma_pkg::CHAN_W-1:0]       r_ch;
    logic [isadma_pkg::COUNT_W-1:0]      r_count, n_count;
    logic                                r_dir;

    // Iteration state of a transfer.
    logic [isadma_pkg::COUNT_W-1:0]      r_rem, n_rem;
    logic [isadma_pkg::COUNT_W-1:0]      r_off, n_off;
    logic [isadma_pkg::IDX_W-1:0]        r_idx, n_idx;

    // Output register.
    logic                                r_o_valid, n_o_valid;
    logic                                r_o_kind, n_o_kind;
    logic [isadma_pkg::STATUS_W-1:0]     r_o_status, n_o_status;
    logic [isadma_pkg::ADDR_W-1:0]       r_o_addr, n_o_addr;
    logic [isadma_pkg::PIECE_W-1:0]      r_o_len, n_o_len;
    logic [isadma_pkg::COUNT_W-1:0]      r_o_off, n_o_off;
    logic                                r_o_dir, n_o_dir;
    logic [isadma_pkg::COUNT_W-1:0]      r_o_granted, n_o_granted;
    logic                                r_o_last, n_o_last;

    isadma_pkg::t_reg_wr                 reg_wr;
    isadma_pkg::t_piece_res              piece_res;
    logic [isadma_pkg::ADDR_W-1:0]       rd_addr;
    logic [isadma_pkg::LEN_W-1:0]        rd_len;
    logic [isadma_pkg::STATUS_W-1:0]     wr_status;
    logic [isadma_pkg::COUNT_W-1:0]      len_plus_one;
    logic                                slot_free;
    logic                                req_take;

    isadma_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (reg_wr),
        .i_rd_ch   (r_ch),
        .o_rd_addr (rd_addr),
        .o_rd_len  (rd_len),
        .o_status  (wr_status)
    );

    isadma_piece_unit u_piece (
        .i_addr (rd_addr),
        .i_rem  (r_rem),
        .i_idx  (r_idx),
        .o_res  (piece_res)
    );

    // A new request is taken only between items; a finished result may still
    // sit in the output register while the next request is taken.
    assign i_req.ready = (r_state == S_IDLE);
    assign req_take    = i_req.valid && i_req.ready;

    // The output register can take a new result when empty or being drained.
    assign slot_free = !r_o_valid || o_res.ready;

    // The grant never exceeds the channel length plus one.
    assign len_plus_one = {1'b0, rd_len} + isadma_pkg::COUNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rem       = r_rem;
        n_off       = r_off;
        n_idx       = r_idx;
        n_o_valid   = r_o_valid && !o_res.ready;
        n_o_kind    = r_o_kind;
        n_o_status  = r_o_status;
        n_o_addr    = r_o_addr;
        n_o_len     = r_o_len;
        n_o_off     = r_o_off;
        n_o_dir     = r_o_dir;
        n_o_granted = r_o_granted;
        n_o_last    = r_o_last;

        reg_wr.port_we = 1'b0;
        reg_wr.port    = r_port;
        reg_wr.data    = r_data;
        reg_wr.addr_we = 1'b0;
        reg_wr.ch      = r_ch;
        reg_wr.addr    = piece_res.next_addr;

        case (r_state)
            S_IDLE: begin
                if (req_take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd == isadma_pkg::CMD_PORT_WRITE) begin
                    // Port write: update the registers and report a status.
                    if (slot_free) begin
                        reg_wr.port_we = 1'b1;
                        n_o_valid      = 1'b1;
                        n_o_kind       = isadma_pkg::KIND_STATUS;
                        n_o_status     = wr_status;
                        n_o_addr       = '0;
                        n_o_len        = '0;
                        n_o_off        = '0;
                        n_o_dir        = 1'b0;
                        n_o_granted    = '0;
                        n_o_last       = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    // Transfer: settle the grant, then split it into pieces.
                    if (r_count > {1'b0, rd_len}) begin
                        n_count = len_plus_one;
                        n_rem   = len_plus_one;
                    end else begin
                        n_count = r_count;
                        n_rem   = r_count;
                    end
                    n_off   = '0;
                    n_idx   = '0;
                    n_state = S_PIECE;
                end
            end
            S_PIECE: begin
                // One page piece per cycle while the output slot is free; an empty grant gives
                // one piece of length zero at the current address.
                if (slot_free) begin
                    reg_wr.addr_we = 1'b1;
                    n_o_valid      = 1'b1;
                    n_o_kind       = isadma_pkg::KIND_PIECE;
                    n_o_status     = isadma_pkg::ST_OK;
                    n_o_addr       = rd_addr;
                    n_o_len        = piece_res.piece[isadma_pkg::PIECE_W-1:0];
                    n_o_off        = r_off;
                    n_o_dir        = r_dir;
                    n_o_granted    = r_count;
                    n_o_last       = piece_res.final_piece;
                    n_rem          = r_rem - piece_res.piece;
                    n_off          = r_off + piece_res.piece;
                    n_idx          = r_idx + isadma_pkg::IDX_W'(1);
                    if (piece_res.final_piece) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_cmd   <= i_req.command;
            r_port  <= i_req.port;
            r_data  <= i_req.data_byte;
            r_ch    <= i_req.channel;
            r_count <= i_req.byte_count;
            r_dir   <= i_req.direction;
        end else begin
            r_count <= n_count;
        end
        r_rem       <= n_rem;
        r_off       <= n_off;
        r_idx       <= n_idx;
        r_o_kind    <= n_o_kind;
        r_o_status  <= n_o_status;
        r_o_addr    <= n_o_addr;
        r_o_len     <= n_o_len;
        r_o_off     <= n_o_off;
        r_o_dir     <= n_o_dir;
        r_o_granted <= n_o_granted;
        r_o_last    <= n_o_last;
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.kind          = r_o_kind;
    assign o_res.status        = r_o_status;
    assign o_res.mem_address   = r_o_addr;
    assign o_res.piece_length  = r_o_len;
    assign o_res.buffer_offset = r_o_off;
    assign o_res.to_buffer     = r_o_dir;
    assign o_res.granted_count = r_o_granted;
    assign o_res.last          = r_o_last;

endmodule

@@ verif/isa_dma_channel_controller_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ISA DMA channel controller testbench
// Drives port writes and transfer requests through the request channel and
// checks every status and page piece against inline answers or a cycle-free
// emulation of the controller registers. A directed table comes first, then random
// traffic built mostly from complete channel 2 setup sequences, with random stalls
// on both channels, a long result hold-off and full drain pauses.
// ----------------------------------------------------------------------------
module isa_dma_channel_controller_tb;
    import isadma_pkg::*;

    localparam int RANDOM_ITEMS   = 294;
    localparam int DIRECTED_ROWS  = 26;
    localparam int HOLDOFF_AT     = 90;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int QUIET_FROM     = 200;
    localparam int QUIET_TO       = 270;
    localparam int DRAIN_CYCLES   = 40;
    localparam int STALL_LIMIT    = 3000;

    typedef struct packed {
        logic                command;
        logic [PORT_W-1:0]   port;
        logic [DATA_W-1:0]   data_byte;
        logic [CHAN_W-1:0]   channel;
        logic [COUNT_W-1:0]  byte_count;
        logic                direction;
    } t_dma_req;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   mem_address;
        logic [PIECE_W-1:0]  piece_length;
        logic [COUNT_W-1:0]  buffer_offset;
        logic                to_buffer;
        logic [COUNT_W-1:0]  granted_count;
        logic                last;
    } t_dma_res;

    // One stimulus row; rows with has_answer set carry their result inline.
    typedef struct packed {
        logic     has_answer;
        t_dma_req req;
        t_dma_res res;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    isadma_in_if  req_if ();
    isadma_out_if res_if ();

    isa_dma_channel_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the controller registers.
    logic [ADDR_W-1:0] shadow_addr [NUM_CHANS];
    logic [LEN_W-1:0]  shadow_len  [NUM_CHANS];
    logic [MASK_W-1:0] shadow_mask [NUM_CHANS];
    logic [MODE_W-1:0] shadow_mode [NUM_CHANS];
    logic              shadow_flop;

    t_stim_row stim_rows [$];
    t_stim_row directed_rows [DIRECTED_ROWS];
    t_dma_res  predicted_now [$];
    t_dma_res  awaited_results [$];

    int taken_count    = 0;
    int write_count    = 0;
    int transfer_count = 0;
    int results_checked = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;
    bit holdoff_done   = 1'b0;

    // Applies one request to the shadow registers and appends the results it
    // causes to predicted_now.
    function automatic void emulate_controller(input t_dma_req r);
        logic [CHAN_W-1:0] ch;
        logic [DATA_W-1:0] d;
        t_dma_res x;
        int grant;
        int rem;
        int off;
        int piece;
        int n;

        d = r.data_byte;
        ch = d[CHAN_W-1:0];
        x = '0;
        if (r.command == CMD_PORT_WRITE) begin
            x.kind = KIND_STATUS;
            x.status = ST_OK;
            x.last = 1'b1;
            case (r.port)
                PORT_MASK: shadow_mask[ch] = d[DATA_W-1:2];
                PORT_CLEAR: shadow_flop = 1'b0;
                PORT_MODE: begin
                    shadow_mode[ch] = d[3:2];
                    // The mode value is kept even when the upper nibble is zero.
                    if (d[7:4] == 4'd0) x.status = ST_BAD_MODE;
                end
                PORT_PAGE2: shadow_addr[PAGED_CHAN][ADDR_W-1:16] = d;
                PORT_ADDR2: begin
                    if (shadow_flop) shadow_addr[PAGED_CHAN][15:8] = d;
                    else shadow_addr[PAGED_CHAN][7:0] = d;
                    shadow_flop = ~shadow_flop;
                end
                PORT_COUNT2: begin
                    if (shadow_flop) shadow_len[PAGED_CHAN][15:8] = d;
                    else shadow_len[PAGED_CHAN][7:0] = d;
                    shadow_flop = ~shadow_flop;
                end
                default: x.status = ST_NO_PORT;
            endcase
            predicted_now.push_back(x);
            return;
        end

        // Transfers ignore mask and mode entirely.
        ch = r.channel;
        grant = int'(r.byte_count);
        if (grant > int'(shadow_len[ch])) grant = int'(shadow_len[ch]) + 1;

        x.kind = KIND_PIECE;
        x.status = ST_OK;
        x.to_buffer = r.direction;
        if (grant == 0) begin
            x.mem_address = shadow_addr[ch];
            x.last = 1'b1;
            predicted_now.push_back(x);
            return;
        end

        rem = grant;
        off = 0;
        n = 0;
        while (rem > 0) begin
            piece = PAGE_BYTES - (int'(shadow_addr[ch]) % PAGE_BYTES);
            if (piece > rem) piece = rem;
            // Pieces beyond the result limit are not reported, but the
            // address still moves over them.
            if (n < MAX_PIECES) begin
                x.mem_address = shadow_addr[ch];
                x.piece_length = PIECE_W'(piece);
                x.buffer_offset = COUNT_W'(off);
                x.granted_count = COUNT_W'(grant);
                x.last = (rem == piece) || (n == MAX_PIECES - 1);
                predicted_now.push_back(x);
                n++;
            end
            rem -= piece;
            off += piece;
            shadow_addr[ch] = shadow_addr[ch] + ADDR_W'(piece);
        end
    endfunction

    function automatic t_dma_req port_wr(input logic [PORT_W-1:0] p,
                                         input logic [DATA_W-1:0] d);
        t_dma_req r;
        r = '0;
        r.command = CMD_PORT_WRITE;
        r.port = p;
        r.data_byte = d;
        return r;
    endfunction

    function automatic t_dma_req xfer(input logic [CHAN_W-1:0] ch,
                                      input logic [COUNT_W-1:0] cnt,
                                      input logic dir);
        t_dma_req r;
        r = '0;
        r.command = CMD_TRANSFER;
        r.channel = ch;
        r.byte_count = cnt;
        r.direction = dir;
        return r;
    endfunction

    function automatic t_dma_res status_of(input logic [STATUS_W-1:0] st);
        t_dma_res x;
        x = '0;
        x.kind = KIND_STATUS;
        x.status = st;
        x.last = 1'b1;
        return x;
    endfunction

    function automatic t_dma_res one_piece(input logic [ADDR_W-1:0] a,
                                           input logic [PIECE_W-1:0] len,
                                           input logic dir,
                                           input logic [COUNT_W-1:0] grant);
        t_dma_res x;
        x = '0;
        x.kind = KIND_PIECE;
        x.status = ST_OK;
        x.mem_address = a;
        x.piece_length = len;
        x.to_buffer = dir;
        x.granted_count = grant;
        x.last = 1'b1;
        return x;
    endfunction

    // Queues a row that is checked against the emulation. The fields that
    // the command does not use get random values.
    function automatic void push_plain(input t_dma_req r);
        t_stim_row row;
        if (r.command == CMD_PORT_WRITE) begin
            r.channel = CHAN_W'($urandom_range(0, 3));
            r.byte_count = COUNT_W'($urandom);
            r.direction = 1'($urandom_range(0, 1));
        end else begin
            r.port = PORT_W'($urandom);
            r.data_byte = DATA_W'($urandom);
        end
        row = '0;
        row.req = r;
        stim_rows.push_back(row);
    endfunction

    // Mostly small requests, now and then any 17-bit value.
    function automatic logic [COUNT_W-1:0] random_count();
        if ($urandom_range(0, 5) == 0) return COUNT_W'($urandom);
        return COUNT_W'($urandom_range(0, 1200));
    endfunction

    function automatic logic [DATA_W-1:0] rand_byte();
        return DATA_W'($urandom_range(0, 255));
    endfunction

    // Random stall decision shared by both channels, switched off for a
    // stretch of the run.
    function automatic bit take_break();
        if (taken_count >= QUIET_FROM && taken_count < QUIET_TO) return 1'b0;
        return ($urandom_range(0, 99) < 34);
    endfunction

    function automatic void report_field(input string field,
                                         input logic [31:0] want_v,
                                         input logic [31:0] got_v);
        if (got_v !== want_v) begin
            if (error_count < 40)
                $display("%0t tb: %s mismatch, expected %0h actual %0h",
                         $time, field, want_v, got_v);
            error_count++;
        end
    endfunction

    initial begin
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Request side: builds the stimulus, then offers one row at a time and
    // records the expected results of each accepted transfer.
    initial begin : request_driver
        int idx;
        int directed_count;
        int pick;
        int reps;
        int pause_marks [$];
        bit offering;
        t_stim_row row;

        req_if.valid      <= 1'b0;
        req_if.command    <= CMD_PORT_WRITE;
        req_if.port       <= '0;
        req_if.data_byte  <= '0;
        req_if.channel    <= '0;
        req_if.byte_count <= '0;
        req_if.direction  <= 1'b0;

        for (int c = 0; c < NUM_CHANS; c++) begin
            shadow_addr[c] = '0;
            shadow_len[c]  = '0;
            shadow_mask[c] = '0;
            shadow_mode[c] = '0;
        end
        shadow_flop = 1'b0;

        directed_rows = '{
            // Straight after reset every length is zero: a grant of at most 1.
            '{1'b1, xfer(2'd0, 17'd5, 1'b1), one_piece(24'h0, 13'd1, 1'b1, 17'd1)},
            '{1'b1, xfer(2'd1, 17'd0, 1'b0), one_piece(24'h0, 13'd0, 1'b0, 17'd0)},
            // Undecoded ports, including both ends of the port range.
            '{1'b1, port_wr(16'h1234, 8'h5a), status_of(ST_NO_PORT)},
            '{1'b1, port_wr(16'hffff, 8'hff), status_of(ST_NO_PORT)},
            '{1'b1, port_wr(16'h0000, 8'h00), status_of(ST_NO_PORT)},
            // Mode byte with a zero upper nibble is flagged but stored.
            '{1'b1, port_wr(PORT_MODE, 8'h05), status_of(ST_BAD_MODE)},
            '{1'b1, port_wr(PORT_MODE, 8'hf6), status_of(ST_OK)},
            '{1'b1, port_wr(PORT_MASK, 8'hff), status_of(ST_OK)},
            '{1'b1, port_wr(PORT_MASK, 8'h00), status_of(ST_OK)},
            // Channel 2 at 0xfff0ff with the largest length.
            '{1'b1, port_wr(PORT_CLEAR, 8'h00), status_of(ST_OK)},
            '{1'b1, port_wr(PORT_ADDR2, 8'hff), status_of(ST_OK)},
            '{1'b1, port_wr(PORT_ADDR2, 8'hf0), status_of(ST_OK)},
            '{1'b1, port_wr(PORT_PAGE2, 8'hff), status_of(ST_OK)},
            '{1'b1, port_wr(PORT_COUNT2, 8'hff), status_of(ST_OK)},
            '{1'b1, port_wr(PORT_COUNT2, 8'hff), status_of(ST_OK)},
            // Full 64 KiB grants from an unaligned address: the piece limit
            // and the 24-bit wrap.
            '{1'b0, xfer(PAGED_CHAN, 17'h10000, 1'b1), '0},
            '{1'b0, xfer(PAGED_CHAN, 17'h1ffff, 1'b0), '0},
            // Channel 2 page aligned at zero with a length of one page.
            '{1'b1, port_wr(PORT_CLEAR, 8'hff), status_of(ST_OK)},
            '{1'b1, port_wr(PORT_ADDR2, 8'h00), status_of(ST_OK)},
            '{1'b1, port_wr(PORT_ADDR2, 8'h00), status_of(ST_OK)},
            '{1'b1, port_wr(PORT_PAGE2, 8'h00), status_of(ST_OK)},
            '{1'b1, port_wr(PORT_COUNT2, 8'h00), status_of(ST_OK)},
            '{1'b1, port_wr(PORT_COUNT2, 8'h10), status_of(ST_OK)},
            '{1'b0, xfer(PAGED_CHAN, 17'd4096, 1'b1), '0},
            '{1'b0, xfer(PAGED_CHAN, 17'h01001, 1'b0), '0},
            // A masked channel still transfers.
            '{1'b0, xfer(2'd3, 17'd1, 1'b0), '0}
        };
        foreach (directed_rows[i]) stim_rows.push_back(directed_rows[i]);
        directed_count = stim_rows.size();

        while (stim_rows.size() < directed_count + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // Complete channel 2 setup followed by a few transfers.
                push_plain(port_wr(PORT_CLEAR, rand_byte()));
                push_plain(port_wr(PORT_ADDR2, rand_byte()));
                push_plain(port_wr(PORT_ADDR2, rand_byte()));
                push_plain(port_wr(PORT_PAGE2, rand_byte()));
                push_plain(port_wr(PORT_COUNT2, rand_byte()));
                if ($urandom_range(0, 3) == 0)
                    push_plain(port_wr(PORT_COUNT2, rand_byte()));
                else
                    push_plain(port_wr(PORT_COUNT2, DATA_W'($urandom_range(0, 4))));
                reps = $urandom_range(1, 3);
                repeat (reps)
                    push_plain(xfer(PAGED_CHAN, random_count(), 1'($urandom_range(0, 1))));
            end else if (pick < 60) begin
                // Half a setup: the flip-flop is left in whatever state.
                push_plain(port_wr(PORT_ADDR2, rand_byte()));
                push_plain(xfer(PAGED_CHAN, random_count(), 1'($urandom_range(0, 1))));
            end else if (pick < 78) begin
                push_plain(xfer(CHAN_W'($urandom_range(0, 3)), random_count(),
                                1'($urandom_range(0, 1))));
            end else if (pick < 92) begin
                case ($urandom_range(0, 5))
                    0: push_plain(port_wr(PORT_MASK, rand_byte()));
                    1: push_plain(port_wr(PORT_MODE, rand_byte()));
                    2: push_plain(port_wr(PORT_CLEAR, rand_byte()));
                    3: push_plain(port_wr(PORT_PAGE2, rand_byte()));
                    4: push_plain(port_wr(PORT_ADDR2, rand_byte()));
                    default: push_plain(port_wr(PORT_COUNT2, rand_byte()));
                endcase
            end else begin
                push_plain(port_wr(PORT_W'($urandom), rand_byte()));
            end
        end

        // The sender drains the block fully at these points.
        pause_marks.push_back(directed_count);
        pause_marks.push_back(directed_count + 160);

        wait (i_rst_n === 1'b1);
        idx = 0;
        offering = 1'b0;
        while (idx < stim_rows.size()) begin
            @(posedge i_clk);
            if (offering && req_if.ready) begin
                emulate_controller(stim_rows[idx].req);
                if (stim_rows[idx].has_answer)
                    awaited_results.push_back(stim_rows[idx].res);
                else
                    foreach (predicted_now[k]) awaited_results.push_back(predicted_now[k]);
                predicted_now.delete();
                if (stim_rows[idx].req.command == CMD_TRANSFER) transfer_count++;
                else write_count++;
                taken_count++;
                idx++;
                offering = 1'b0;
            end
            if (!offering && pause_marks.size() != 0 && idx == pause_marks[0]) begin
                void'(pause_marks.pop_front());
                req_if.valid <= 1'b0;
                do @(posedge i_clk); while (awaited_results.size() != 0);
            end
            if (!offering) begin
                if (idx < stim_rows.size() && !take_break()) begin
                    row = stim_rows[idx];
                    req_if.command    <= row.req.command;
                    req_if.port       <= row.req.port;
                    req_if.data_byte  <= row.req.data_byte;
                    req_if.channel    <= row.req.channel;
                    req_if.byte_count <= row.req.byte_count;
                    req_if.direction  <= row.req.direction;
                    req_if.valid      <= 1'b1;
                    offering = 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d requests taken (%0d port writes, %0d transfers), %0d results checked",
                 taken_count, write_count, transfer_count, results_checked);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: compares each transfer with the oldest expectation and
    // stalls at random, with one long hold-off to back the block up.
    initial begin : result_checker
        t_dma_res want;

        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                results_checked++;
                if (awaited_results.size() == 0) begin
                    if (error_count < 40)
                        $display("%0t tb: result with nothing awaited, expected none actual %0h",
                                 $time, {res_if.kind, res_if.status, res_if.mem_address,
                                         res_if.piece_length, res_if.last});
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    report_field("kind", 32'(want.kind), 32'(res_if.kind));
                    report_field("status", 32'(want.status), 32'(res_if.status));
                    report_field("mem_address", 32'(want.mem_address), 32'(res_if.mem_address));
                    report_field("piece_length", 32'(want.piece_length),
                                 32'(res_if.piece_length));
                    report_field("buffer_offset", 32'(want.buffer_offset),
                                 32'(res_if.buffer_offset));
                    report_field("to_buffer", 32'(want.to_buffer), 32'(res_if.to_buffer));
                    report_field("granted_count", 32'(want.granted_count),
                                 32'(res_if.granted_count));
                    report_field("last", 32'(want.last), 32'(res_if.last));
                end
            end
            if (!holdoff_done && taken_count >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end
            res_if.ready <= !take_break();
        end
    end

    // Watchdog: too long without any transfer on either channel.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

@@ isa_dma_channel_controller.f @@
hw/rtl/isadma_pkg.sv
hw/rtl/isadma_in_if.sv
hw/rtl/isadma_out_if.sv
hw/rtl/isadma_regs.sv
hw/rtl/isadma_piece_unit.sv
hw/rtl/isa_dma_channel_controller.sv
verif/isa_dma_channel_controller_tb.sv
